FILE: hdl/min_jerk_trajectory_defines.svh
// assertion macros shared by the minimum-jerk trajectory rtl
`ifndef MIN_JERK_TRAJECTORY_DEFINES_SVH
`define MIN_JERK_TRAJECTORY_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MJT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("min_jerk_trajectory: check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MJT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("min_jerk_trajectory: check failed");

`endif

FILE: hdl/mjt_pkg.sv
// shared widths, register codes and types of the minimum-jerk trajectory block
`default_nettype none
package mjt_pkg;

    localparam int TIME_W = 32;
    localparam int POS_W  = 32;
    localparam int VEL_W  = 48;
    localparam int ACC_W  = 64;
    localparam int DUR_W  = 31;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_START    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TARGET   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DURATION = 2'd2;

    // flags that ride along with a word down the pipe
    typedef struct packed {
        logic special;
        logic use_start;
    } t_flags;

endpackage
`default_nettype wire

FILE: hdl/mjt_channels.sv
// valid/ready channel interfaces for sample times and trajectory words
`default_nettype none
interface mjt_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [mjt_pkg::TIME_W-1:0]  sample_time;

    modport source (output valid, output sample_time, input ready);
    modport sink   (input valid, input sample_time, output ready);
endinterface

interface mjt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mjt_pkg::POS_W-1:0]   position;
    logic signed [mjt_pkg::VEL_W-1:0]   velocity;
    logic signed [mjt_pkg::ACC_W-1:0]   acceleration;

    modport source (output valid, output position, output velocity, output acceleration,
                    input ready);
    modport sink   (input valid, input position, input velocity, input acceleration,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/mjt_div.sv
// pipelined restoring divider, one quotient bit per register stage
`default_nettype none
module mjt_div #(
    parameter int DIV_W = 31,
    parameter int Q_W   = 32,
    parameter int SB_W  = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [DIV_W-1:0] i_rem,
    input  wire logic [Q_W-1:0]   i_num,
    input  wire logic [DIV_W-1:0] i_den,
    input  wire logic [SB_W-1:0]  i_sb,
    output logic                  o_valid,
    output logic [Q_W-1:0]        o_quo,
    output logic [SB_W-1:0]       o_sb
);

    logic [DIV_W-1:0] w_rem [Q_W+1];
    logic [Q_W-1:0]   w_num [Q_W+1];
    logic [Q_W-1:0]   w_quo [Q_W+1];
    logic [SB_W-1:0]  w_sb  [Q_W+1];
    logic [Q_W:0]     w_vld;

    assign w_rem[0] = i_rem;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_sb[0]  = i_sb;
    assign w_vld[0] = i_valid;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DIV_W:0]   w_trial;
        logic [DIV_W:0]   w_diff;
        logic             w_ge;
        logic [DIV_W-1:0] r_rem;
        logic [Q_W-1:0]   r_num;
        logic [Q_W-1:0]   r_quo;
        logic [SB_W-1:0]  r_sb;
        logic             r_vld;

        // bring down the next dividend bit and try the subtract
        assign w_trial = {w_rem[k], w_num[k][Q_W-1]};
        assign w_diff  = w_trial - {1'b0, i_den};
        assign w_ge    = w_trial >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_num <= {w_num[k][Q_W-2:0], 1'b0};
                r_quo <= {w_quo[k][Q_W-2:0], w_ge};
                r_sb  <= w_sb[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_num[k+1] = r_num;
        assign w_quo[k+1] = r_quo;
        assign w_sb[k+1]  = r_sb;
        assign w_vld[k+1] = r_vld;
    end

    assign o_valid = w_vld[Q_W];
    assign o_quo   = w_quo[Q_W];
    assign o_sb    = w_sb[Q_W];

endmodule
`default_nettype wire

FILE: hdl/min_jerk_trajectory.sv
// minimum-jerk (quintic) trajectory generator, top level
// usage:
//  - software writes start position, target position (Q16.16) and move length
//    in ticks through the write port (i_cfg_we, i_cfg_index, i_cfg_data) while
//    nothing is in flight; index 3 is ignored
//  - each word on i_in carries a signed sample time in ticks since move start
//  - each word on o_out carries position (Q16.16), velocity (Q16.32 per tick)
//    and acceleration (Q16.48 per tick squared), saturated where too large
//  - negative time or zero length gives the start position, time at or past
//    the end gives the target, both with zero velocity and acceleration
// timing:
//  - one word in and one word out per cycle unless o_out stalls; the pipe is
//    one input stage, 32 stages for the time/length quotient, four polynomial
//    stages, 71 stages for the velocity and acceleration quotients, one output
//    stage; the 71-stage dividers set the latency, one quotient bit per stage
// reset and stall:
//  - synchronous reset empties the pipe and clears the move registers to zero
//  - when o_out is stalled the whole pipe freezes and i_in.ready drops;
//    the waiting word is held, nothing is lost or repeated
`default_nettype none
`include "min_jerk_trajectory_defines.svh"
module min_jerk_trajectory (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [mjt_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [mjt_pkg::CFG_W-1:0]   i_cfg_data,
    mjt_in_if.sink                           i_in,
    mjt_out_if.source                        o_out
);

    localparam int Q_W = 71;

    // configuration registers
    logic [31:0] r_start;
    logic [31:0] r_target;
    logic [30:0] r_dur;
    logic [61:0] r_dur_sq;

    // global advance: the pipe moves unless the output word is stuck
    logic w_en;
    logic r_out_vld;
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_target <= '0;
            r_dur    <= '0;
            r_dur_sq <= '0;
        end else begin
            r_dur_sq <= 62'(r_dur) * 62'(r_dur);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mjt_pkg::CFG_START:    r_start  <= i_cfg_data;
                    mjt_pkg::CFG_TARGET:   r_target <= i_cfg_data;
                    mjt_pkg::CFG_DURATION: r_dur    <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // move distance, sign and magnitude
    logic [32:0] w_d;
    logic        w_dneg;
    logic [32:0] w_dm;
    assign w_d    = {r_target[31], r_target} - {r_start[31], r_start};
    assign w_dneg = w_d[32];
    assign w_dm   = w_dneg ? 33'(-w_d) : w_d;

    // stage a: classify the sample time
    logic            w_neg;
    logic            w_zero_dur;
    logic            w_past;
    mjt_pkg::t_flags w_a_flags;
    logic            r_a_vld;
    mjt_pkg::t_flags r_a_flags;
    logic [30:0]     r_a_rem;

    assign w_neg               = i_in.sample_time[31];
    assign w_zero_dur          = (r_dur == '0);
    assign w_past              = i_in.sample_time[30:0] >= r_dur;
    assign w_a_flags.special   = w_neg || w_zero_dur || w_past;
    assign w_a_flags.use_start = w_neg || w_zero_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_flags <= w_a_flags;
            r_a_rem   <= i_in.sample_time[30:0];
        end
    end

    // s = t * 2^32 / T as a Q0.32 fraction
    logic            w_s_vld;
    logic [31:0]     w_s;
    mjt_pkg::t_flags w_s_flags;

    mjt_div #(.DIV_W(31), .Q_W(32), .SB_W($bits(mjt_pkg::t_flags))) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_vld),
        .i_rem   (r_a_rem),
        .i_num   (32'd0),
        .i_den   (r_dur),
        .i_sb    (r_a_flags),
        .o_valid (w_s_vld),
        .o_quo   (w_s),
        .o_sb    (w_s_flags)
    );

    // p1: s(1-s), s^2, |1-2s|
    logic [32:0]     w_u;
    logic [64:0]     w_su_prod;
    logic [63:0]     w_s2_prod;
    logic [33:0]     w_two_s;
    logic            w_wneg;
    logic [33:0]     w_wm;
    logic            r_p1_vld;
    mjt_pkg::t_flags r_p1_flags;
    logic [31:0]     r_p1_s;
    logic [30:0]     r_p1_su;
    logic [31:0]     r_p1_s2;
    logic [32:0]     r_p1_wm;
    logic            r_p1_wneg;

    assign w_u       = 33'h1_0000_0000 - {1'b0, w_s};
    assign w_su_prod = 65'(w_s) * 65'(w_u);
    assign w_s2_prod = 64'(w_s) * 64'(w_s);
    assign w_two_s   = {1'b0, w_s, 1'b0};
    assign w_wneg    = w_two_s > 34'h1_0000_0000;
    assign w_wm      = w_wneg ? w_two_s - 34'h1_0000_0000 : 34'h1_0000_0000 - w_two_s;

    // p2: (s(1-s))^2, s(1-s)|1-2s|, s^3, 10 - 15s + 6s^2
    logic [61:0]     w_su2_prod;
    logic [63:0]     w_suw_prod;
    logic [63:0]     w_s3_prod;
    logic [36:0]     w_inner;
    logic            r_p2_vld;
    mjt_pkg::t_flags r_p2_flags;
    logic            r_p2_wneg;
    logic [29:0]     r_p2_su2;
    logic [31:0]     r_p2_suw;
    logic [31:0]     r_p2_s3;
    logic [35:0]     r_p2_inner;

    assign w_su2_prod = 62'(r_p1_su) * 62'(r_p1_su);
    assign w_suw_prod = 64'(r_p1_su) * 64'(r_p1_wm);
    assign w_s3_prod  = 64'(r_p1_s2) * 64'(r_p1_s);
    assign w_inner    = (37'd10 << 32) + 37'(r_p1_s2) * 37'd6 - 37'(r_p1_s) * 37'd15;

    // p3: velocity and acceleration shapes, position shape capped at one
    logic [34:0]     w_pv;
    logic [37:0]     w_pa;
    logic [67:0]     w_pp_prod;
    logic [35:0]     w_pp;
    logic            r_p3_vld;
    mjt_pkg::t_flags r_p3_flags;
    logic            r_p3_wneg;
    logic [34:0]     r_p3_pv;
    logic [37:0]     r_p3_pa;
    logic [32:0]     r_p3_pp;

    assign w_pv      = 35'(r_p2_su2) * 35'd30;
    assign w_pa      = 38'(r_p2_suw) * 38'd60;
    assign w_pp_prod = 68'(r_p2_s3) * 68'(r_p2_inner);
    assign w_pp      = w_pp_prod[67:32];

    // p4: scale all three by the distance magnitude
    logic [65:0]     w_pm_prod;
    logic [67:0]     w_xv_prod;
    logic [70:0]     w_xa_prod;
    logic            r_p4_vld;
    mjt_pkg::t_flags r_p4_flags;
    logic            r_p4_wneg;
    logic [32:0]     r_p4_pm;
    logic [51:0]     r_p4_xv;
    logic [70:0]     r_p4_xa;

    assign w_pm_prod = 66'(w_dm) * 66'(r_p3_pp);
    assign w_xv_prod = 68'(w_dm) * 68'(r_p3_pv);
    assign w_xa_prod = 71'(w_dm) * 71'(r_p3_pa);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= w_s_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_flags <= w_s_flags;
            r_p1_s     <= w_s;
            r_p1_su    <= w_su_prod[62:32];
            r_p1_s2    <= w_s2_prod[63:32];
            r_p1_wm    <= w_wm[32:0];
            r_p1_wneg  <= w_wneg;

            r_p2_flags <= r_p1_flags;
            r_p2_wneg  <= r_p1_wneg;
            r_p2_su2   <= w_su2_prod[61:32];
            r_p2_suw   <= w_suw_prod[63:32];
            r_p2_s3    <= w_s3_prod[63:32];
            r_p2_inner <= w_inner[35:0];

            r_p3_flags <= r_p2_flags;
            r_p3_wneg  <= r_p2_wneg;
            r_p3_pv    <= w_pv;
            r_p3_pa    <= w_pa;
            r_p3_pp    <= (w_pp > 36'h1_0000_0000) ? 33'h1_0000_0000 : w_pp[32:0];

            r_p4_flags <= r_p3_flags;
            r_p4_wneg  <= r_p3_wneg;
            r_p4_pm    <= w_pm_prod[64:32];
            r_p4_xv    <= w_xv_prod[67:16];
            r_p4_xa    <= w_xa_prod;
        end
    end

    // interpolated position goes down the acceleration divider as side data
    logic [33:0] w_start34;
    logic [33:0] w_pos34;
    assign w_start34 = {{2{r_start[31]}}, r_start};
    assign w_pos34   = w_dneg ? w_start34 - 34'(r_p4_pm) : w_start34 + 34'(r_p4_pm);

    // velocity: (|d| pv / 2^16) / T ; acceleration: |d| pa / T^2
    logic            w_v_vld;
    logic [Q_W-1:0]  w_vq;
    mjt_pkg::t_flags w_v_flags;
    logic            w_acc_vld;
    logic [Q_W-1:0]  w_aq;
    logic [32:0]     w_a_sb;

    mjt_div #(.DIV_W(31), .Q_W(Q_W), .SB_W($bits(mjt_pkg::t_flags))) u_div_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p4_vld),
        .i_rem   (31'd0),
        .i_num   (Q_W'(r_p4_xv)),
        .i_den   (r_dur),
        .i_sb    (r_p4_flags),
        .o_valid (w_v_vld),
        .o_quo   (w_vq),
        .o_sb    (w_v_flags)
    );

    mjt_div #(.DIV_W(62), .Q_W(Q_W), .SB_W(33)) u_div_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p4_vld),
        .i_rem   (62'd0),
        .i_num   (r_p4_xa),
        .i_den   (r_dur_sq),
        .i_sb    ({r_p4_wneg, w_pos34[31:0]}),
        .o_valid (w_acc_vld),
        .o_quo   (w_aq),
        .o_sb    (w_a_sb)
    );

    // saturation toward the signed range of each output
    logic        w_aneg;
    logic [47:0] w_vel;
    logic [63:0] w_acc;
    logic [31:0] w_pos;

    assign w_aneg = w_dneg ^ w_a_sb[32];

    always_comb begin
        if (w_dneg) begin
            w_vel = (w_vq > (Q_W'(1) << 47)) ? 48'h8000_0000_0000 : 48'(-w_vq[47:0]);
        end else begin
            w_vel = (w_vq > ((Q_W'(1) << 47) - Q_W'(1))) ? 48'h7FFF_FFFF_FFFF : w_vq[47:0];
        end
        if (w_aneg) begin
            w_acc = (w_aq > (Q_W'(1) << 63)) ? 64'h8000_0000_0000_0000 : 64'(-w_aq[63:0]);
        end else begin
            w_acc = (w_aq > ((Q_W'(1) << 63) - Q_W'(1))) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                          : w_aq[63:0];
        end
        if (w_v_flags.special) begin
            w_pos = w_v_flags.use_start ? r_start : r_target;
            w_vel = '0;
            w_acc = '0;
        end else begin
            w_pos = w_a_sb[31:0];
        end
    end

    // output register
    logic [31:0] r_out_pos;
    logic [47:0] r_out_vel;
    logic [63:0] r_out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_v_vld && w_acc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pos <= w_pos;
            r_out_vel <= w_vel;
            r_out_acc <= w_acc;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.position     = r_out_pos;
    assign o_out.velocity     = r_out_vel;
    assign o_out.acceleration = r_out_acc;

    // checks
    logic [4:0] w_vld_vec;
    logic       w_fwd_ok;
    assign w_vld_vec = {r_a_vld, r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld};
    assign w_fwd_ok  = ($signed(r_out_pos) >= $signed(r_start))
                    && ($signed(r_out_pos) <= $signed(r_target));

    `MJT_ASSERT_IMPL(a_vel_sign, r_out_vld && (r_out_vel != '0), r_out_vel[47] == w_dneg)
    `MJT_ASSERT_IMPL(a_pos_between, r_out_vld && !w_dneg, w_fwd_ok)
    `MJT_ASSERT_NEXT(a_stall_holds, !w_en, $stable(w_vld_vec))

endmodule
`default_nettype wire
